// ===== hdl/i2cmbe_pkg.sv =====
// Shared types and constants for the I2C master bit engine.
// No dependencies; the sequencer and the top level refer to this package by scoped names.
`timescale 1ns / 1ps

package i2cmbe_pkg;

  localparam int unsigned TickW = 16;
  localparam logic [TickW-1:0] PhaseTicksReset = 16'd10;

  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_SEND  = 3'd3,
    CMD_READ  = 3'd4,
    CMD_WAIT  = 3'd5,
    CMD_ACK   = 3'd6,
    CMD_NACK  = 3'd7
  } cmd_t;

  // Per-tick result produced by the sequencer.
  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       idle;
    logic       done;
    logic [7:0] rx;
    logic       nack;
  } res_t;

endpackage

// ===== hdl/i2cmbe_in_if.sv =====
// Input channel: one base tick with optional command, tx byte and sampled SDA.
// Stand-alone valid/ready interface; no package dependency.
`timescale 1ns / 1ps

interface i2cmbe_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] op;
  logic [7:0] tx_byte;
  logic       sda_in;

  modport source (output valid, output op, output tx_byte, output sda_in, input ready);
  modport sink   (input valid, input op, input tx_byte, input sda_in, output ready);
endinterface

// ===== hdl/i2cmbe_out_if.sv =====
// Output channel: pin levels and status for each accepted tick.
// Stand-alone valid/ready interface; no package dependency.
`timescale 1ns / 1ps

interface i2cmbe_out_if;
  logic       valid;
  logic       ready;
  logic       scl_out;
  logic       sda_out;
  logic       ready_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       nack_seen;

  modport source (output valid, output scl_out, output sda_out, output ready_res,
                  output done_res, output rx_byte, output nack_seen, input ready);
  modport sink   (input valid, input scl_out, input sda_out, input ready_res,
                  input done_res, input rx_byte, input nack_seen, output ready);
endinterface

// ===== hdl/i2cmbe_seq.sv =====
// Phase sequencer: command state, phase tick counter, shift register, pins.
// Depends on i2cmbe_pkg (cmd_t, res_t, TickW).
`timescale 1ns / 1ps

module i2cmbe_seq (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  logic [2:0]                  op,
  input  logic [7:0]                  tx_byte,
  input  logic                        sda_in,
  input  logic [i2cmbe_pkg::TickW-1:0] phase_ticks,
  output i2cmbe_pkg::res_t            res
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_PH0  = 4'b0010,
    ST_PH1  = 4'b0100,
    ST_PH2  = 4'b1000
  } step_t;

  step_t                         state, state_next;
  i2cmbe_pkg::cmd_t              cmd, cmd_next;
  logic [2:0]                    bit_idx, bit_idx_next;
  logic [7:0]                    shift, shift_next;
  logic [i2cmbe_pkg::TickW-1:0]  tick, tick_next;
  logic                          scl, scl_next;
  logic                          sda, sda_next;
  logic                          ack, ack_next;
  logic [7:0]                    rx_hold, rx_hold_next;
  logic [i2cmbe_pkg::TickW-1:0]  len;
  logic                          enter;
  step_t                         ent_ph;
  logic                          last_ph;
  logic                          done;

  always_comb begin
    state_next   = state;
    cmd_next     = cmd;
    bit_idx_next = bit_idx;
    shift_next   = shift;
    tick_next    = tick;
    scl_next     = scl;
    sda_next     = sda;
    ack_next     = ack;
    rx_hold_next = rx_hold;
    enter        = 1'b0;
    ent_ph       = ST_PH0;
    done         = 1'b0;
    last_ph      = 1'b0;
    len          = (phase_ticks == '0) ? {{(i2cmbe_pkg::TickW-1){1'b0}}, 1'b1} : phase_ticks;

    case (state)
      ST_IDLE: begin
        if (i2cmbe_pkg::cmd_t'(op) != i2cmbe_pkg::CMD_NONE) begin
          cmd_next     = i2cmbe_pkg::cmd_t'(op);
          bit_idx_next = 3'd0;
          shift_next   = (i2cmbe_pkg::cmd_t'(op) == i2cmbe_pkg::CMD_SEND) ? tx_byte : 8'd0;
          enter        = 1'b1;
          ent_ph       = ST_PH0;
        end
      end
      default: begin
        if (tick < len) begin
          tick_next = tick + 1'b1;
        end else begin
          // sample points sit at the end of the SCL-high phase
          if (cmd == i2cmbe_pkg::CMD_READ && state == ST_PH0) begin
            shift_next = {shift[6:0], sda_in};
          end
          if (cmd == i2cmbe_pkg::CMD_WAIT && state == ST_PH1) begin
            ack_next = sda_in;
          end
          last_ph = (state == ST_PH0 && cmd == i2cmbe_pkg::CMD_STOP) ||
                    (state == ST_PH1 && cmd == i2cmbe_pkg::CMD_READ) ||
                    (state == ST_PH2);
          if (!last_ph) begin
            enter  = 1'b1;
            ent_ph = (state == ST_PH0) ? ST_PH1 : ST_PH2;
          end else if ((cmd == i2cmbe_pkg::CMD_SEND || cmd == i2cmbe_pkg::CMD_READ) &&
                       bit_idx != 3'd7) begin
            bit_idx_next = bit_idx + 3'd1;
            enter        = 1'b1;
            ent_ph       = ST_PH0;
          end else begin
            if (cmd == i2cmbe_pkg::CMD_STOP || cmd == i2cmbe_pkg::CMD_ACK) begin
              sda_next = 1'b1;
            end
            if (cmd == i2cmbe_pkg::CMD_READ) begin
              rx_hold_next = shift_next;
            end
            state_next = ST_IDLE;
            tick_next  = '0;
            done       = 1'b1;
          end
        end
      end
    endcase

    // pin actions on the first tick of a phase
    if (enter) begin
      state_next = ent_ph;
      tick_next  = {{(i2cmbe_pkg::TickW-1){1'b0}}, 1'b1};
      case (cmd_next)
        i2cmbe_pkg::CMD_START: begin
          if (ent_ph == ST_PH0) begin
            sda_next = 1'b1;
            scl_next = 1'b1;
          end else if (ent_ph == ST_PH1) begin
            sda_next = 1'b0;
          end else begin
            scl_next = 1'b0;
          end
        end
        i2cmbe_pkg::CMD_STOP: begin
          sda_next = 1'b0;
          scl_next = 1'b1;
        end
        i2cmbe_pkg::CMD_SEND: begin
          if (ent_ph == ST_PH0) begin
            sda_next = shift_next[7];
          end else if (ent_ph == ST_PH1) begin
            scl_next = 1'b1;
          end else begin
            scl_next = 1'b0;
            if (bit_idx_next == 3'd7) begin
              sda_next = 1'b1;  // release SDA for the ACK slot
            end
            shift_next = {shift_next[6:0], 1'b0};
          end
        end
        i2cmbe_pkg::CMD_READ: begin
          scl_next = (ent_ph == ST_PH0);
        end
        i2cmbe_pkg::CMD_WAIT, i2cmbe_pkg::CMD_ACK, i2cmbe_pkg::CMD_NACK: begin
          if (ent_ph == ST_PH0) begin
            sda_next = (cmd_next != i2cmbe_pkg::CMD_ACK);
          end else if (ent_ph == ST_PH1) begin
            scl_next = 1'b1;
          end else begin
            scl_next = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      cmd     <= i2cmbe_pkg::CMD_NONE;
      bit_idx <= 3'd0;
      shift   <= 8'd0;
      tick    <= '0;
      scl     <= 1'b1;
      sda     <= 1'b1;
      ack     <= 1'b0;
      rx_hold <= 8'd0;
    end else if (adv) begin
      state   <= state_next;
      cmd     <= cmd_next;
      bit_idx <= bit_idx_next;
      shift   <= shift_next;
      tick    <= tick_next;
      scl     <= scl_next;
      sda     <= sda_next;
      ack     <= ack_next;
      rx_hold <= rx_hold_next;
    end
  end

  assign res.scl  = scl_next;
  assign res.sda  = sda_next;
  assign res.idle = (state_next == ST_IDLE);
  assign res.done = done;
  assign res.rx   = rx_hold_next;
  assign res.nack = ack_next;

`ifndef SYNTHESIS
  a_busy_tick: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> tick != '0)
    else $error("busy phase with zero tick count");
  a_bit_cmd: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE && bit_idx != 3'd0) |->
      (cmd == i2cmbe_pkg::CMD_SEND || cmd == i2cmbe_pkg::CMD_READ))
    else $error("bit index advanced for a non-byte command");
  a_ph2_cmd: assert property (@(posedge clk) disable iff (rst)
    state == ST_PH2 |-> (cmd != i2cmbe_pkg::CMD_STOP && cmd != i2cmbe_pkg::CMD_READ))
    else $error("third phase reached by a short command");
`endif

endmodule

// ===== hdl/i2c_master_bit_engine_core.sv =====
// Top level of the I2C master bit engine: handshake, phase length register,
// result register. Depends on i2cmbe_pkg, i2cmbe_in_if, i2cmbe_out_if, i2cmbe_seq.
`timescale 1ns / 1ps

// Open-drain I2C master bit engine. Each input item is one base tick that
// carries the sampled SDA level and an optional command (start, stop, send
// byte, read byte, wait ACK, ACK, NACK); each accepted item yields exactly one
// result item with the SCL/SDA drive levels (1 = released), ready_res, a
// done_res pulse, the last read byte and the last ACK status. Throughput is
// one item per clock: the sequencer updates its state in the cycle an item is
// accepted and the result lands in a single output register, so the result
// is valid in the next cycle and the input stays ready while that register is
// empty or being drained. Every bus phase lasts phase_ticks ticks (0 acts as 1);
// write the register through phase_ticks_we/phase_ticks_wdata only while the
// engine is idle. Commands issued while a command is running are dropped.
module i2c_master_bit_engine_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         phase_ticks_we,
  input  logic [i2cmbe_pkg::TickW-1:0] phase_ticks_wdata,
  i2cmbe_in_if.sink                    in_ch,
  i2cmbe_out_if.source                 out_ch
);

  logic [i2cmbe_pkg::TickW-1:0] phase_ticks;
  logic                         in_acc;
  logic                         out_valid;
  i2cmbe_pkg::res_t             res;
  i2cmbe_pkg::res_t             res_q;

  // phase length register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks <= i2cmbe_pkg::PhaseTicksReset;
    end else if (phase_ticks_we) begin
      phase_ticks <= phase_ticks_wdata;
    end
  end

  // take a tick whenever the result slot is free or emptying this cycle
  assign in_ch.ready = !out_valid || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  i2cmbe_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .adv         (in_acc),
    .op          (in_ch.op),
    .tx_byte     (in_ch.tx_byte),
    .sda_in      (in_ch.sda_in),
    .phase_ticks (phase_ticks),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_acc) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  // payload only, no reset needed
  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_q <= res;
    end
  end

  assign out_ch.valid     = out_valid;
  assign out_ch.scl_out   = res_q.scl;
  assign out_ch.sda_out   = res_q.sda;
  assign out_ch.ready_res = res_q.idle;
  assign out_ch.done_res  = res_q.done;
  assign out_ch.rx_byte   = res_q.rx;
  assign out_ch.nack_seen = res_q.nack;

`ifndef SYNTHESIS
  a_acc_to_out: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> out_valid)
    else $error("accepted item did not produce a result");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && res_q.done) |-> res_q.idle)
    else $error("done reported while still busy");
  a_cfg_hold: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$past(phase_ticks_we)) |-> $stable(phase_ticks))
    else $error("phase length changed without a write");
`endif

endmodule
